// ===== design/crtc_trls_pkg.sv =====
// Shared types and constants for the CRTC text raster line sequencer.
// No dependencies; imported by crtc_trls_core, the top level and the testbench.
package crtc_trls_pkg;

  localparam logic [4:0] LAST_SCAN_ROW   = 5'd13;
  localparam logic [4:0] SYNC_LINES      = 5'd16;
  localparam logic [1:0] CURSOR_OFF_MODE = 2'b01;

  localparam int CFG_DATA_BITS  = 14;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HORIZ_DISPLAYED = 3'd0,
    REG_VERT_TOTAL      = 3'd1,
    REG_VERT_ADJUST     = 3'd2,
    REG_VERT_DISPLAYED  = 3'd3,
    REG_VSYNC_POSITION  = 3'd4,
    REG_CURSOR_START    = 3'd5,
    REG_CURSOR_END      = 3'd6,
    REG_START_ADDRESS   = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  horiz_displayed;
    logic [6:0]  vert_total;
    logic [4:0]  vert_adjust;
    logic [6:0]  vert_displayed;
    logic [6:0]  vsync_position;
    logic [6:0]  cursor_start;
    logic [4:0]  cursor_end;
    logic [13:0] start_address;
  } cfg_t;

  typedef struct packed {
    logic [13:0] line_address;
    logic [4:0]  scan_row;
    logic        display_active;
    logic        cursor_visible;
    logic        status_display_off;
    logic        status_vsync;
    logic        frame_end;
    logic        blink_phase;
  } line_result_t;

endpackage

// ===== design/crtc_text_raster_line_sequencer.sv =====
// Top level of the CRTC text raster line sequencer: config registers, input
// and result registers around crtc_trls_core. Depends on crtc_trls_pkg.
//
// One transfer on the input channel is one scan-line tick; a tick with
// line_tick = 1 yields one result transfer, a tick with line_tick = 0 is
// absorbed with no result. The block sustains one tick per clock while the
// receiver is ready: a tick is held in the input register, evaluated by the
// combinational next-state logic of the timing core, and lands in the result
// register, so each result passes the input and result registers. Input ready
// follows output ready combinationally when the result register is full and
// the input register holds a tick with line_tick = 1. Character height is
// fixed at 14 scan lines; write registers only while no tick is in flight.
module crtc_text_raster_line_sequencer
  import crtc_trls_pkg::*;
#(
  parameter int ADDRESS_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      line_tick,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [13:0]               line_address,
  output logic [4:0]                scan_row,
  output logic                      display_active,
  output logic                      cursor_visible,
  output logic                      status_display_off,
  output logic                      status_vsync,
  output logic                      frame_end,
  output logic                      blink_phase
);

  cfg_t         cfg;
  logic         in_full;
  logic         in_tick;
  logic         process;
  logic         step;
  line_result_t res;
  line_result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        REG_HORIZ_DISPLAYED: cfg.horiz_displayed <= wr_data[7:0];
        REG_VERT_TOTAL:      cfg.vert_total      <= wr_data[6:0];
        REG_VERT_ADJUST:     cfg.vert_adjust     <= wr_data[4:0];
        REG_VERT_DISPLAYED:  cfg.vert_displayed  <= wr_data[6:0];
        REG_VSYNC_POSITION:  cfg.vsync_position  <= wr_data[6:0];
        REG_CURSOR_START:    cfg.cursor_start    <= wr_data[6:0];
        REG_CURSOR_END:      cfg.cursor_end      <= wr_data[4:0];
        REG_START_ADDRESS:   cfg.start_address   <= wr_data[13:0];
        default: ;
      endcase
    end
  end

  assign process  = in_full && (!in_tick || !out_valid || out_ready);
  assign step     = process && in_tick;
  assign in_ready = !in_full || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_tick <= line_tick;
    end
  end

  crtc_trls_core #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .step(step),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign line_address       = out_res.line_address;
  assign scan_row           = out_res.scan_row;
  assign display_active     = out_res.display_active;
  assign cursor_visible     = out_res.cursor_visible;
  assign status_display_off = out_res.status_display_off;
  assign status_vsync       = out_res.status_vsync;
  assign frame_end          = out_res.frame_end;
  assign blink_phase        = out_res.blink_phase;

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_full && in_tick && !out_valid |=> out_valid)
    else $error("pending tick did not produce a result");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !step)
    else $error("result overwritten while stalled");

endmodule

// ===== design/crtc_trls_core.sv =====
// Vertical timing state and per-line next-state logic of the sequencer.
// Depends on crtc_trls_pkg; instantiated by crtc_text_raster_line_sequencer.
module crtc_trls_core
  import crtc_trls_pkg::*;
#(
  parameter int ADDRESS_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         step,
  output line_result_t res
);

  logic [4:0]              scan_line_count, scan_line_count_next;
  logic [6:0]              row_count, row_count_next;
  logic [ADDRESS_BITS-1:0] current_address, current_address_next;
  logic [ADDRESS_BITS-1:0] row_start_address, row_start_address_next;
  logic [4:0]              adjust_remaining, adjust_remaining_next;
  logic                    display_enable, display_enable_next;
  logic                    cursor_line_on, cursor_line_on_next;
  logic                    cursor_blink_on, cursor_blink_on_next;
  logic [4:0]              sync_remaining, sync_remaining_next;
  logic                    sync_flag, sync_flag_next;
  logic [3:0]              frame_counter, frame_counter_next;

  logic                    frame_end;
  logic [6:0]              row_inc;
  logic [ADDRESS_BITS-1:0] frame_start;
  logic [ADDRESS_BITS+13:0] addr_ext;

  assign frame_start = ADDRESS_BITS'(cfg.start_address);
  assign row_inc     = row_count + 7'd1;
  assign addr_ext    = {14'd0, current_address};

  always_comb begin
    scan_line_count_next   = scan_line_count;
    row_count_next         = row_count;
    current_address_next   = current_address;
    row_start_address_next = row_start_address;
    adjust_remaining_next  = adjust_remaining;
    display_enable_next    = display_enable;
    cursor_line_on_next    = cursor_line_on;
    cursor_blink_on_next   = cursor_blink_on;
    sync_remaining_next    = sync_remaining;
    sync_flag_next         = sync_flag;
    frame_counter_next     = frame_counter;
    frame_end              = 1'b0;

    if (display_enable) begin
      current_address_next = current_address + ADDRESS_BITS'(cfg.horiz_displayed);
    end
    if (row_count == cfg.vsync_position && scan_line_count == 5'd0) begin
      sync_flag_next = 1'b1;
    end
    if (sync_remaining != 5'd0) begin
      sync_remaining_next = sync_remaining - 5'd1;
      if (sync_remaining == 5'd1) begin
        sync_flag_next = 1'b0;
      end
    end
    if (scan_line_count == cfg.cursor_end) begin
      cursor_line_on_next = 1'b0;
    end

    if (adjust_remaining != 5'd0) begin
      scan_line_count_next  = scan_line_count + 5'd1;
      current_address_next  = row_start_address;
      adjust_remaining_next = adjust_remaining - 5'd1;
      if (adjust_remaining == 5'd1) begin
        display_enable_next    = 1'b1;
        current_address_next   = frame_start;
        row_start_address_next = frame_start;
        scan_line_count_next   = 5'd0;
      end
    end else if (scan_line_count == LAST_SCAN_ROW) begin
      row_start_address_next = current_address_next;
      scan_line_count_next   = 5'd0;
      row_count_next         = row_inc;
      if (row_inc == cfg.vert_displayed) begin
        display_enable_next = 1'b0;
      end
      if (row_count == cfg.vert_total) begin
        row_count_next        = 7'd0;
        adjust_remaining_next = cfg.vert_adjust;
        if (cfg.vert_adjust == 5'd0) begin
          display_enable_next    = 1'b1;
          current_address_next   = frame_start;
          row_start_address_next = frame_start;
        end
        if (cfg.cursor_start[6:5] == CURSOR_OFF_MODE) begin
          cursor_blink_on_next = 1'b0;
        end else begin
          cursor_blink_on_next = frame_counter[3];
        end
      end
      if (row_count_next == cfg.vsync_position) begin
        display_enable_next = 1'b0;
        sync_remaining_next = SYNC_LINES;
        frame_counter_next  = frame_counter + 4'd1;
        frame_end           = 1'b1;
      end
    end else begin
      scan_line_count_next = scan_line_count + 5'd1;
      current_address_next = row_start_address;
    end

    if (scan_line_count_next == cfg.cursor_start[4:0]) begin
      cursor_line_on_next = 1'b1;
    end
  end

  always_comb begin
    res.line_address       = addr_ext[13:0];
    res.scan_row           = scan_line_count;
    res.display_active     = display_enable;
    res.cursor_visible     = cursor_line_on & cursor_blink_on;
    res.status_display_off = ~display_enable_next;
    res.status_vsync       = sync_flag_next;
    res.frame_end          = frame_end;
    res.blink_phase        = frame_counter_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_line_count   <= '0;
      row_count         <= '0;
      current_address   <= '0;
      row_start_address <= '0;
      adjust_remaining  <= '0;
      display_enable    <= 1'b0;
      cursor_line_on    <= 1'b0;
      cursor_blink_on   <= 1'b0;
      sync_remaining    <= '0;
      sync_flag         <= 1'b0;
      frame_counter     <= '0;
    end else if (step) begin
      scan_line_count   <= scan_line_count_next;
      row_count         <= row_count_next;
      current_address   <= current_address_next;
      row_start_address <= row_start_address_next;
      adjust_remaining  <= adjust_remaining_next;
      display_enable    <= display_enable_next;
      cursor_line_on    <= cursor_line_on_next;
      cursor_blink_on   <= cursor_blink_on_next;
      sync_remaining    <= sync_remaining_next;
      sync_flag         <= sync_flag_next;
      frame_counter     <= frame_counter_next;
    end
  end

  a_sync_bound: assert property (@(posedge clk) disable iff (rst)
    sync_remaining <= SYNC_LINES)
    else $error("vsync timer above its load value");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(scan_line_count) && $stable(row_count) && $stable(current_address))
    else $error("timing state moved without a line");

  a_frame_end_loads_sync: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_end |=> sync_remaining == SYNC_LINES)
    else $error("frame end did not load the vsync timer");

endmodule

// ===== tb/crtc_text_raster_line_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crtc_text_raster_line_sequencer: scan-line ticks
// are checked against an in-bench model of the vertical CRTC timing.
// Depends on crtc_trls_pkg and the top level of the design.
module crtc_text_raster_line_sequencer_tb;
  import crtc_trls_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 60;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] wr_index = '0;
  logic [CFG_DATA_BITS-1:0]  wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      line_tick = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [13:0]               line_address;
  logic [4:0]                scan_row;
  logic                      display_active;
  logic                      cursor_visible;
  logic                      status_display_off;
  logic                      status_vsync;
  logic                      frame_end;
  logic                      blink_phase;

  crtc_text_raster_line_sequencer dut (
    .clk                (clk),
    .rst                (rst),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .line_tick          (line_tick),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .line_address       (line_address),
    .scan_row           (scan_row),
    .display_active     (display_active),
    .cursor_visible     (cursor_visible),
    .status_display_off (status_display_off),
    .status_vsync       (status_vsync),
    .frame_end          (frame_end),
    .blink_phase        (blink_phase)
  );

  // timing model: register copy and counter state
  cfg_t        crtc_cfg = '0;
  logic [4:0]  scan_line = '0;
  logic [6:0]  char_row = '0;
  logic [13:0] line_addr_q = '0;
  logic [13:0] row_addr_q = '0;
  logic [4:0]  adjust_left = '0;
  logic [4:0]  sync_left = '0;
  logic        disp_en = 1'b0;
  logic        cur_line = 1'b0;
  logic        cur_blink = 1'b0;
  logic        vsync_on = 1'b0;
  logic [3:0]  frames = '0;

  line_result_t expected_lines[$];

  int  mismatches = 0;
  int  lines_sent = 0;
  int  lines_checked = 0;
  int  frame_ends_seen = 0;
  int  settings_applied = 0;
  int  cycles = 0;
  bit  steady = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_lines.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic void open_frame();
    disp_en     = 1'b1;
    line_addr_q = crtc_cfg.start_address;
    row_addr_q  = line_addr_q;
  endfunction

  // one scan line: report the drawn line, then advance the end-of-line counters
  function automatic line_result_t draw_scan_line();
    line_result_t r;
    logic [6:0]   prev_row;
    r = '0;
    r.line_address   = line_addr_q;
    r.scan_row       = scan_line;
    r.display_active = disp_en;
    r.cursor_visible = cur_line & cur_blink;
    if (disp_en) line_addr_q = line_addr_q + 14'(crtc_cfg.horiz_displayed);
    if (char_row == crtc_cfg.vsync_position && scan_line == 5'd0) vsync_on = 1'b1;
    if (sync_left != 5'd0) begin
      sync_left = sync_left - 5'd1;
      if (sync_left == 5'd0) vsync_on = 1'b0;
    end
    if (scan_line == crtc_cfg.cursor_end) cur_line = 1'b0;
    if (adjust_left != 5'd0) begin
      scan_line   = scan_line + 5'd1;
      line_addr_q = row_addr_q;
      adjust_left = adjust_left - 5'd1;
      if (adjust_left == 5'd0) begin
        open_frame();
        scan_line = 5'd0;
      end
    end else if (scan_line == LAST_SCAN_ROW) begin
      row_addr_q = line_addr_q;
      scan_line  = 5'd0;
      prev_row   = char_row;
      char_row   = char_row + 7'd1;
      if (char_row == crtc_cfg.vert_displayed) disp_en = 1'b0;
      if (prev_row == crtc_cfg.vert_total) begin
        char_row    = 7'd0;
        adjust_left = crtc_cfg.vert_adjust;
        if (adjust_left == 5'd0) open_frame();
        cur_blink = (crtc_cfg.cursor_start[6:5] == CURSOR_OFF_MODE) ? 1'b0 : frames[3];
      end
      if (char_row == crtc_cfg.vsync_position) begin
        disp_en     = 1'b0;
        sync_left   = SYNC_LINES;
        frames      = frames + 4'd1;
        r.frame_end = 1'b1;
      end
    end else begin
      scan_line   = scan_line + 5'd1;
      line_addr_q = row_addr_q;
    end
    if (scan_line == crtc_cfg.cursor_start[4:0]) cur_line = 1'b1;
    r.status_display_off = ~disp_en;
    r.status_vsync       = vsync_on;
    r.blink_phase        = frames[3];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch on result %0d: %s", lines_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [13:0] got, logic [13:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    line_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("result transfer with no line outstanding");
      end else begin
        want = expected_lines.pop_front();
        check_field("line_address", line_address, want.line_address);
        check_field("scan_row", 14'(scan_row), 14'(want.scan_row));
        check_field("display_active", 14'(display_active), 14'(want.display_active));
        check_field("cursor_visible", 14'(cursor_visible), 14'(want.cursor_visible));
        check_field("status_display_off", 14'(status_display_off),
                    14'(want.status_display_off));
        check_field("status_vsync", 14'(status_vsync), 14'(want.status_vsync));
        check_field("frame_end", 14'(frame_end), 14'(want.frame_end));
        check_field("blink_phase", 14'(blink_phase), 14'(want.blink_phase));
        if (want.frame_end) frame_ends_seen++;
      end
      lines_checked++;
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  initial begin : result_sink
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  task automatic send_item(input logic tick);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_valid  <= 1'b0;
        line_tick <= 1'($urandom_range(1));
        @(negedge clk);
      end
    end
    in_valid  <= 1'b1;
    line_tick <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tick) begin
      expected_lines.push_back(draw_scan_line());
      lines_sent++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_HORIZ_DISPLAYED: crtc_cfg.horiz_displayed = data[7:0];
      REG_VERT_TOTAL:      crtc_cfg.vert_total      = data[6:0];
      REG_VERT_ADJUST:     crtc_cfg.vert_adjust     = data[4:0];
      REG_VERT_DISPLAYED:  crtc_cfg.vert_displayed  = data[6:0];
      REG_VSYNC_POSITION:  crtc_cfg.vsync_position  = data[6:0];
      REG_CURSOR_START:    crtc_cfg.cursor_start    = data[6:0];
      REG_CURSOR_END:      crtc_cfg.cursor_end      = data[4:0];
      REG_START_ADDRESS:   crtc_cfg.start_address   = data[13:0];
      default: ;
    endcase
  endtask

  // upper bits of wr_data are random noise above each register's width; the start address uses all 14 bits
  task automatic apply_config(cfg_t c);
    logic [CFG_DATA_BITS-1:0] noise;
    noise = 14'($urandom_range(16383));
    write_reg(REG_HORIZ_DISPLAYED, {noise[13:8], c.horiz_displayed});
    write_reg(REG_VERT_TOTAL, {noise[13:7], c.vert_total});
    write_reg(REG_VERT_ADJUST, {noise[13:5], c.vert_adjust});
    write_reg(REG_VERT_DISPLAYED, {noise[13:7], c.vert_displayed});
    write_reg(REG_VSYNC_POSITION, {noise[13:7], c.vsync_position});
    write_reg(REG_CURSOR_START, {noise[13:7], c.cursor_start});
    write_reg(REG_CURSOR_END, {noise[13:5], c.cursor_end});
    write_reg(REG_START_ADDRESS, c.start_address);
    @(negedge clk);
    wr_en <= 1'b0;
    settings_applied++;
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    c.horiz_displayed = 8'($urandom_range(255));
    c.vert_total      = 7'($urandom_range(4));
    c.vert_adjust     = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                 : 5'($urandom_range(2));
    c.vert_displayed  = 7'($urandom_range(c.vert_total + 1));
    c.vsync_position  = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                                 : 7'($urandom_range(c.vert_total + 1));
    c.cursor_start    = {2'($urandom_range(3)),
                         ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(13))};
    c.cursor_end      = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                 : 5'($urandom_range(13));
    c.start_address   = 14'($urandom_range(16383));
    return c;
  endfunction

  task automatic random_ticks(int count);
    repeat (count) send_item($urandom_range(99) < 88);
  endtask

  // reset settings, idle ticks, then one short frame with adjust and sync at row 0
  task automatic test_directed_frame();
    cfg_t c;
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    wait_idle();
    c.horiz_displayed = 8'd80;
    c.vert_total      = 7'd0;
    c.vert_adjust     = 5'd3;
    c.vert_displayed  = 7'd1;
    c.vsync_position  = 7'd0;
    c.cursor_start    = {2'b00, 5'd2};
    c.cursor_end      = 5'd4;
    c.start_address   = 14'h3ff0;
    apply_config(c);
    repeat (19) send_item(1'b1);
    send_item(1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    c.horiz_displayed = 8'hff;
    c.vert_total      = 7'd127;
    c.vert_adjust     = 5'd31;
    c.vert_displayed  = 7'd127;
    c.vsync_position  = 7'd127;
    c.cursor_start    = 7'h7f;
    c.cursor_end      = 5'd31;
    c.start_address   = 14'h3fff;
    apply_config(c);
    random_ticks(120);
    wait_idle();
    apply_config('0);
    random_ticks(40);
    wait_idle();
    c.vert_total     = 7'd0;
    c.vert_displayed = 7'd0;
    c.vsync_position = 7'd0;
    c.cursor_start   = {CURSOR_OFF_MODE, 5'd0};
    c.cursor_end     = 5'd13;
    apply_config(c);
    random_ticks(80);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    apply_config(random_setting());
    repeat (200) send_item(1'b1);
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    apply_config(random_setting());
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (100) send_item(1'b1);
    wait_idle();
    steady = 1'b0;
  endtask

  // total lowered below the current row: row counter runs through 127 and wraps
  task automatic test_row_counter_wrap();
    cfg_t c;
    c = random_setting();
    c.vert_total     = 7'd127;
    c.vert_adjust    = 5'd0;
    c.vert_displayed = 7'd2;
    c.vsync_position = 7'd3;
    apply_config(c);
    while (char_row < 7'd2) send_item(1'b1);
    wait_idle();
    c.vert_total     = 7'd1;
    c.vert_displayed = 7'd40;
    c.vsync_position = 7'd60;
    apply_config(c);
    while (char_row != 7'd1) send_item(1'b1);
    random_ticks(20);
    wait_idle();
  endtask

  task automatic test_random_frames();
    repeat (9) begin
      apply_config(random_setting());
      random_ticks(40);
      wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_frame();
    test_register_extremes();
    test_back_to_back();
    test_output_backpressure();
    test_random_frames();
    test_row_counter_wrap();
    wait_idle();
    $display("%0d scan lines sent, %0d results checked, %0d frame ends seen",
             lines_sent, lines_checked, frame_ends_seen);
    $display("%0d register settings applied, %0d mismatches", settings_applied, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
